[hw/rtl/msa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msa_pkg: shared types and constants of the metropolis sampling accumulator
// Sequencer states, shared multiplier operation codes and fixed field widths.
// ----------------------------------------------------------------------------
package msa_pkg;

    localparam int Q16_W = 16;
    localparam int SUM_W = 36;
    localparam int SQ_W  = 52;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WEIGHT,
        ST_CHECK,
        ST_DRAW,
        ST_SQUARE,
        ST_PRODUCT,
        ST_DIV_START,
        ST_DIV_RUN,
        ST_ACCUM,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        MUL_WGT,
        MUL_DRAW,
        MUL_SQX,
        MUL_AB,
        MUL_V
    } t_mul_op;

endpackage

[hw/rtl/msa_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msa_mul: shared registered multiplier
// Selects the operand pair for the requested operation and registers the
// product. The (1+x^2) factor is formed from the previous product (x^2).
// ----------------------------------------------------------------------------
module msa_mul #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  msa_pkg::t_mul_op       i_op,
    input  logic [FRAC_BITS-1:0]   i_px,
    input  logic [FRAC_BITS-1:0]   i_cx,
    input  logic [FRAC_BITS:0]     i_wold,
    input  logic [15:0]            i_draw,
    input  logic [15:0]            i_v,
    output logic [2*((FRAC_BITS+3 > 16) ? FRAC_BITS+3 : 16)-1:0] o_prod
);
    import msa_pkg::*;

    localparam int F   = FRAC_BITS;
    localparam int MW  = (F + 3 > 16) ? F + 3 : 16;
    localparam int PW  = 2 * MW;
    localparam int KSH = F + 4;
    // ceil(2^KSH / 3): floor(n*RECIP3 >> KSH) == floor(n/3) for n < 2^(F+3)
    localparam logic [MW-1:0] RECIP3 = MW'(((64'd1 << KSH) + 64'd2) / 64'd3);

    logic [F+2:0]  num_w;
    logic [F:0]    a_op;
    logic [F+1:0]  b_op;
    logic [MW-1:0] opa;
    logic [MW-1:0] opb;
    logic [PW-1:0] r_prod;

    // 4 - 2x, 1 + x^2, 2 - x
    assign num_w = {3'b100, {F{1'b0}}} - {2'b00, i_px, 1'b0};
    assign a_op  = {1'b1, r_prod[2*F-1:F]};
    assign b_op  = {2'b10, {F{1'b0}}} - {2'b00, i_cx};

    always_comb begin
        case (i_op)
            MUL_WGT: begin
                opa = MW'(num_w);
                opb = RECIP3;
            end
            MUL_DRAW: begin
                opa = MW'(i_draw);
                opb = MW'(i_wold);
            end
            MUL_SQX: begin
                opa = MW'(i_cx);
                opb = MW'(i_cx);
            end
            MUL_AB: begin
                opa = MW'(a_op);
                opb = MW'(b_op);
            end
            MUL_V: begin
                opa = MW'(i_v);
                opb = MW'(i_v);
            end
            default: begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PW'(opa) * PW'(opb);
        end
    end

    assign o_prod = r_prod;

endmodule

[hw/rtl/msa_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msa_div: serial restoring divider
// Computes floor(1.5 * 2^(2F) * 2^F / d) one quotient bit per cycle,
// saturating to all ones when the quotient would not fit.
// ----------------------------------------------------------------------------
module msa_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [2*FRAC_BITS+1:0] i_den,
    output logic                   o_done,
    output logic [FRAC_BITS-1:0]   o_quot
);
    import msa_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int RW = 2 * F + 3;
    localparam int CW = $clog2(F + 1);
    localparam logic [RW-1:0] NUM = RW'(3) << (2 * FRAC_BITS - 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [RW-1:0] r_rem;
    logic [RW-1:0] r_den;
    logic [F-1:0]  r_quot;
    logic [RW-1:0] shifted;
    logic          ge;
    logic [RW-1:0] n_rem;
    logic          sat;

    assign shifted = {r_rem[RW-2:0], 1'b0};
    assign ge      = (shifted >= r_den);
    assign n_rem   = ge ? (shifted - r_den) : shifted;
    assign sat     = (NUM >= {1'b0, i_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (sat) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= CW'(F);
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= NUM;
            r_den  <= {1'b0, i_den};
            r_quot <= sat ? '1 : '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[F-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

[hw/rtl/metropolis_sampling_accumulator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// metropolis_sampling_accumulator: metropolis chain step with weighted sums
// Each word proposes a position; the chain moves or stays, then f(x)/w(x)
// and its square are added to saturating sums. A start word seeds the chain and clears the sums instead.
// ----------------------------------------------------------------------------
//  channel   dir  tdata (low bit up)                         tuser
//  s         in   proposal, accept_draw                      start_req
//  m         out  sample, weighted, running_sum,             accepted
//                 running_sum_sq, sample_count, zero pad
//
//  a step runs weight, check, square, product, divider start, divider run,
//  accumulate, output; the serial divider gives one quotient bit per cycle.
//  a draw state comes after check when the weight falls and the accept draw
//  is compared; a start word runs only weight, check and output.
//  i_rst_n is synchronous; it resets the chain to x = 0, w = 1.0, sums zero.
//  a finished word waits in the output register while the next is taken.
// ----------------------------------------------------------------------------
module metropolis_sampling_accumulator #(
    parameter int FRAC_BITS  = 16,
    parameter int COUNT_BITS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,  // proposal[15:0], accept_draw[31:16]
    input  logic        i_s_tuser,  // start_req
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // sample, weighted, running_sum, running_sum_sq, sample_count, zero pad
    output logic [((120+COUNT_BITS+1+7)/8)*8-1:0] o_m_tdata,
    output logic        o_m_tuser   // accepted
);
    import msa_pkg::*;

    localparam int F      = FRAC_BITS;
    localparam int MW     = (F + 3 > 16) ? F + 3 : 16;
    localparam int PW     = 2 * MW;
    localparam int CNTW   = COUNT_BITS + 1;
    localparam int OW_RAW = 2 * Q16_W + SUM_W + SQ_W + CNTW;
    localparam int OW     = ((OW_RAW + 7) / 8) * 8;

    t_state r_state;
    t_state n_state;

    logic [F-1:0]      r_px;
    logic [15:0]       r_draw;
    logic              r_start;
    logic [F:0]        r_wn;
    logic              r_take;
    logic [15:0]       r_v;
    logic [F-1:0]      r_chain_x;
    logic [F:0]        r_chain_w;
    logic [SUM_W-1:0]  r_sum;
    logic [SQ_W-1:0]   r_sumsq;
    logic [CNTW-1:0]   r_cnt;
    logic              r_m_tvalid;
    logic [OW-1:0]     r_m_tdata;
    logic              r_m_tuser;

    logic              mul_en;
    t_mul_op           mul_op;
    logic [PW-1:0]     prod;
    logic              div_start;
    logic              div_done;
    logic [F-1:0]      quot;

    logic [F+15:0]     in_ext;
    logic [F-1:0]      in_x;
    logic [F:0]        wn;
    logic              w_rises;
    logic              draw_ok;
    logic [F+15:0]     quot_ext;
    logic [15:0]       v_q16;
    logic [F+15:0]     cx_ext;
    logic [15:0]       sample;
    logic [SUM_W:0]    sum_add;
    logic [SQ_W:0]     sq_add;
    logic [SUM_W-1:0]  n_sum;
    logic [SQ_W-1:0]   n_sumsq;
    logic              out_free;

    // q0.16 <-> q0.F by shifting through a 16-bit extension
    assign in_ext   = {i_s_tdata[15:0], {F{1'b0}}};
    assign in_x     = in_ext[F+15:16];
    assign quot_ext = {quot, 16'h0000};
    assign v_q16    = quot_ext[F+15:F];
    assign cx_ext   = {r_chain_x, 16'h0000};
    assign sample   = cx_ext[F+15:F];

    assign wn      = prod[2*F+4:F+4];
    assign w_rises = (wn >= r_chain_w);
    assign draw_ok = (prod[F+16:0] <= {r_wn, 16'h0000});

    assign sum_add = {1'b0, r_sum} + (SUM_W+1)'(r_v);
    assign sq_add  = {1'b0, r_sumsq} + (SQ_W+1)'(prod[31:0]);
    assign n_sum   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    assign n_sumsq = sq_add[SQ_W] ? '1 : sq_add[SQ_W-1:0];

    assign out_free = !r_m_tvalid || i_m_tready;

    msa_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_op   (mul_op),
        .i_px   (r_px),
        .i_cx   (r_chain_x),
        .i_wold (r_chain_w),
        .i_draw (r_draw),
        .i_v    (v_q16),
        .o_prod (prod)
    );

    msa_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_den   (prod[2*F+1:0]),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:      if (i_s_tvalid) n_state = ST_WEIGHT;
            ST_WEIGHT:    n_state = ST_CHECK;
            ST_CHECK: begin
                if (r_start) begin
                    n_state = ST_OUT;
                end else if (w_rises) begin
                    n_state = ST_SQUARE;
                end else begin
                    n_state = ST_DRAW;
                end
            end
            ST_DRAW:      n_state = ST_SQUARE;
            ST_SQUARE:    n_state = ST_PRODUCT;
            ST_PRODUCT:   n_state = ST_DIV_START;
            ST_DIV_START: n_state = ST_DIV_RUN;
            ST_DIV_RUN:   if (div_done) n_state = ST_ACCUM;
            ST_ACCUM:     n_state = ST_OUT;
            ST_OUT:       if (out_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        mul_en    = 1'b0;
        mul_op    = MUL_WGT;
        div_start = 1'b0;
        case (r_state)
            ST_WEIGHT: begin
                mul_en = 1'b1;
                mul_op = MUL_WGT;
            end
            ST_CHECK: begin
                mul_en = !r_start && !w_rises;
                mul_op = MUL_DRAW;
            end
            ST_SQUARE: begin
                mul_en = 1'b1;
                mul_op = MUL_SQX;
            end
            ST_PRODUCT: begin
                mul_en = 1'b1;
                mul_op = MUL_AB;
            end
            ST_DIV_START: div_start = 1'b1;
            ST_DIV_RUN: begin
                mul_en = div_done;
                mul_op = MUL_V;
            end
            default: begin
                mul_en    = 1'b0;
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_chain_x  <= '0;
            r_chain_w  <= (F+1)'(1) << F;
            r_sum      <= '0;
            r_sumsq    <= '0;
            r_cnt      <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_CHECK: begin
                    if (r_start || w_rises) begin
                        r_chain_x <= r_px;
                        r_chain_w <= wn;
                    end
                    if (r_start) begin
                        r_sum   <= '0;
                        r_sumsq <= '0;
                        r_cnt   <= '0;
                    end
                end
                ST_DRAW: begin
                    if (draw_ok) begin
                        r_chain_x <= r_px;
                        r_chain_w <= r_wn;
                    end
                end
                ST_ACCUM: begin
                    r_sum   <= n_sum;
                    r_sumsq <= n_sumsq;
                    if (!r_cnt[COUNT_BITS]) begin
                        r_cnt <= r_cnt + CNTW'(1);
                    end
                end
                default: begin
                    r_sum <= r_sum;
                end
            endcase
            if (r_state == ST_OUT && out_free) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_s_tvalid) begin
            r_px    <= in_x;
            r_draw  <= i_s_tdata[31:16];
            r_start <= i_s_tuser;
        end
        if (r_state == ST_CHECK) begin
            r_wn   <= wn;
            r_take <= r_start || w_rises;
            if (r_start) begin
                r_v <= '0;
            end
        end
        if (r_state == ST_DRAW) begin
            r_take <= draw_ok;
        end
        if (r_state == ST_DIV_RUN && div_done) begin
            r_v <= v_q16;
        end
        if (r_state == ST_OUT && out_free) begin
            r_m_tdata <= OW'({r_cnt, r_sumsq, r_sum, r_v, sample});
            r_m_tuser <= r_take;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

endmodule

[tb/sv/metropolis_step_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// metropolis_step_checker: chain predictor and result scoreboard
// Watches the input and output channels. It steps its own copy of the
// Metropolis chain for every input word taken, and checks each output word
// field by field against the oldest predicted step.
// ----------------------------------------------------------------------------
module metropolis_step_checker #(
    parameter int COUNT_BITS = 20,
    parameter int M_W        = ((120+COUNT_BITS+1+7)/8)*8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    input  logic           i_s_tready,
    input  logic [31:0]    i_s_tdata,   // proposal, accept_draw
    input  logic           i_s_tuser,   // start_req
    input  logic           i_m_tvalid,
    input  logic           i_m_tready,
    // sample, weighted, running_sum, running_sum_sq, sample_count, zero pad
    input  logic [M_W-1:0] i_m_tdata,
    input  logic           i_m_tuser,   // accepted
    output int             o_fail_count,
    output int             o_pending
);
    import msa_pkg::*;

    localparam int          FRAC  = 16;
    localparam logic [63:0] ONE   = 64'd1 << FRAC;
    localparam int          CNT_W = COUNT_BITS + 1;

    typedef struct packed {
        logic [Q16_W-1:0] sample;
        logic [Q16_W-1:0] weighted;
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  sum_sq;
        logic [CNT_W-1:0] count;
        logic             accepted;
    } t_step_result;

    // predicted chain state
    logic [15:0]      chain_pos  = '0;
    logic [16:0]      chain_wt   = 17'(ONE);
    logic [SUM_W-1:0] acc_sum    = '0;
    logic [SQ_W-1:0]  acc_sum_sq = '0;
    logic [CNT_W-1:0] acc_count  = '0;

    t_step_result predicted_steps[$];
    int           fail_count = 0;

    assign o_fail_count = fail_count;

    // w(x) = (4 - 2x) / 3 in Q1.16
    function automatic logic [16:0] weight_at(input logic [15:0] x);
        logic [63:0] num;
        num = 4 * ONE - 2 * 64'(x);
        return 17'(num / 3);
    endfunction

    task automatic advance_chain(input logic [15:0] prop, input logic [15:0] draw,
                                 input logic start, output t_step_result res);
        logic [16:0]      w_new;
        logic             take;
        logic [63:0]      a, b, d, rem, quo;
        logic [SUM_W:0]   sum_next;
        logic [SQ_W:0]    sq_next;
        res  = '0;
        take = 1'b1;
        if (start) begin
            chain_pos  = prop;
            chain_wt   = weight_at(prop);
            acc_sum    = '0;
            acc_sum_sq = '0;
            acc_count  = '0;
        end else begin
            w_new = weight_at(prop);
            // the draw only matters when the weight falls
            if (w_new < chain_wt)
                take = (64'(draw) * 64'(chain_wt)) <= (64'(w_new) << 16);
            if (take) begin
                chain_pos = prop;
                chain_wt  = w_new;
            end
            // v = (3/2) / ((1 + x^2) * (2 - x)), restoring division
            a   = ONE + ((64'(chain_pos) * 64'(chain_pos)) >> FRAC);
            b   = 2 * ONE - 64'(chain_pos);
            d   = a * b;
            rem = 64'd3 << (2 * FRAC - 1);
            if (rem >= d) begin
                quo = ONE - 1;
            end else begin
                quo = '0;
                for (int i = 0; i < FRAC; i++) begin
                    rem = rem << 1;
                    quo = quo << 1;
                    if (rem >= d) begin
                        rem    = rem - d;
                        quo[0] = 1'b1;
                    end
                end
            end
            res.weighted = quo[15:0];
            sum_next     = {1'b0, acc_sum} + (SUM_W+1)'(res.weighted);
            acc_sum      = sum_next[SUM_W] ? '1 : sum_next[SUM_W-1:0];
            sq_next      = {1'b0, acc_sum_sq} + (SQ_W+1)'(32'(res.weighted) * 32'(res.weighted));
            acc_sum_sq   = sq_next[SQ_W] ? '1 : sq_next[SQ_W-1:0];
            if (64'(acc_count) < (64'd1 << COUNT_BITS))
                acc_count = acc_count + 1'b1;
        end
        res.sample   = chain_pos;
        res.sum      = acc_sum;
        res.sum_sq   = acc_sum_sq;
        res.count    = acc_count;
        res.accepted = take;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                         $realtime, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_step_result got, want;
        if (!i_rst_n) begin
            chain_pos  = '0;
            chain_wt   = 17'(ONE);
            acc_sum    = '0;
            acc_sum_sq = '0;
            acc_count  = '0;
            predicted_steps.delete();
        end else begin
            // retire first: a word leaving now belongs to an earlier input
            if (i_m_tvalid && i_m_tready) begin
                got.sample   = i_m_tdata[15:0];
                got.weighted = i_m_tdata[31:16];
                got.sum      = i_m_tdata[32 +: SUM_W];
                got.sum_sq   = i_m_tdata[68 +: SQ_W];
                got.count    = i_m_tdata[120 +: CNT_W];
                got.accepted = i_m_tuser;
                if (predicted_steps.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t ns: output word with no step pending", $realtime);
                end else begin
                    want = predicted_steps.pop_front();
                    check_field("sample", 64'(want.sample), 64'(got.sample));
                    check_field("weighted", 64'(want.weighted), 64'(got.weighted));
                    check_field("running_sum", 64'(want.sum), 64'(got.sum));
                    check_field("running_sum_sq", 64'(want.sum_sq), 64'(got.sum_sq));
                    check_field("sample_count", 64'(want.count), 64'(got.count));
                    check_field("accepted", 64'(want.accepted), 64'(got.accepted));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                advance_chain(i_s_tdata[15:0], i_s_tdata[31:16], i_s_tuser, want);
                predicted_steps.push_back(want);
            end
        end
        o_pending <= predicted_steps.size();
    end

endmodule

[tb/sv/tb_metropolis_sampling_accumulator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_metropolis_sampling_accumulator: stimulus and verdict for the sampler
// Sends directed chain steps (steps before a start, starts, rising, equal
// and falling weights, draws at the acceptance threshold), then random
// steps with occasional restarts, under random idling on both channels.
// The checker beside the block predicts and compares every output word.
// ----------------------------------------------------------------------------
module tb_metropolis_sampling_accumulator;

    localparam int FRAC_BITS  = 16;
    localparam int COUNT_BITS = 20;
    localparam int M_W        = ((120+COUNT_BITS+1+7)/8)*8;
    localparam int NUM_RANDOM = 1400;
    localparam int LONG_HOLD  = 500;

    logic           i_clk      = 1'b0;
    logic           i_rst_n    = 1'b0;
    logic           i_s_tvalid = 1'b0;
    logic           o_s_tready;
    logic [31:0]    i_s_tdata  = '0;   // proposal, accept_draw
    logic           i_s_tuser  = 1'b0; // start_req
    logic           o_m_tvalid;
    logic           i_m_tready = 1'b0;
    // sample, weighted, running_sum, running_sum_sq, sample_count, zero pad
    logic [M_W-1:0] o_m_tdata;
    logic           o_m_tuser;         // accepted

    int fail_count;
    int steps_pending;
    int hold_off_req  = 0;
    int hold_off_done = 0;
    int stall_left    = 0;
    bit no_idle       = 1'b0;

    metropolis_sampling_accumulator #(
        .FRAC_BITS  (FRAC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    metropolis_step_checker #(
        .COUNT_BITS (COUNT_BITS),
        .M_W        (M_W)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (steps_pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // output side: random stalls, plus a long hold-off when requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            stall_left <= 0;
        end else if (hold_off_done != hold_off_req) begin
            hold_off_done <= hold_off_req;
            i_m_tready    <= 1'b0;
            stall_left    <= LONG_HOLD;
        end else if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (no_idle || $urandom_range(0, 99) < 60) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= 1'b0;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 3);
        end
    end

    function automatic int idle_len();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_word(input logic [15:0] prop, input logic [15:0] draw,
                             input logic start);
        int gap;
        gap = idle_len();
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {draw, prop};
        i_s_tuser  <= start;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        if (gap > 0) begin
            // junk on the bus while idle must be ignored
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= $urandom;
            i_s_tuser  <= 1'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge i_clk);
        while (steps_pending != 0);
    endtask

    initial begin
        int          kind;
        logic [15:0] prop, draw;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // steps before any start run from x = 0, w = 1.0
        send_word(16'h8000, 16'h0000, 1'b0);   // equal weight
        send_word(16'hFFFF, 16'hFFFF, 1'b0);   // falls, rejected
        send_word(16'hFFFF, 16'h0000, 1'b0);   // falls, zero draw takes it
        // start at the top end, draw ignored
        send_word(16'hFFFF, 16'hFFFF, 1'b1);
        send_word(16'h0000, 16'hFFFF, 1'b0);   // rising weight
        // from x = 0 to x = max: threshold draw is 32768
        send_word(16'hFFFF, 16'd32769, 1'b0);
        send_word(16'hFFFF, 16'd32768, 1'b0);
        send_word(16'hFFFF, 16'hFFFF, 1'b0);   // stays, equal weight
        send_word(16'h0000, 16'h0000, 1'b1);   // start at zero
        send_word(16'h0000, 16'hFFFF, 1'b0);
        send_word(16'h0001, 16'hFFFF, 1'b0);   // tiny fall
        send_word(16'h5555, 16'hAAAA, 1'b0);
        send_word(16'hAAAA, 16'h5555, 1'b0);
        send_word(16'h1234, 16'hFFFF, 1'b1);
        send_word(16'hFFFF, 16'h0000, 1'b0);
        send_word(16'h8000, 16'h7FFF, 1'b0);
        i_s_tvalid <= 1'b0;
        wait_drained();

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n % 100 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            // output held off while input keeps coming
            if (n == 350)
                hold_off_req <= hold_off_req + 1;
            if (n == 700) begin
                i_s_tvalid <= 1'b0;
                wait_drained();
            end
            kind = $urandom_range(0, 99);
            prop = 16'($urandom);
            draw = 16'($urandom);
            if (kind < 8)
                prop = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            else if (kind < 14)
                draw = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            send_word(prop, draw, kind >= 96);
        end
        i_s_tvalid <= 1'b0;

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
